// File: src/tsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int VALUE_BITS = 10;
    localparam int DUTY_BITS = 16;
    localparam int CEILING_BITS = 10;
    localparam int STEP_BITS = 11;
    localparam int POINT_BITS = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DUTY_CEILING = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_DIVIDER = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DUTY_STEP = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_POINTS = 2'd3;

    localparam logic [CEILING_BITS-1:0] CEILING_RESET = 10'd500;
    localparam logic [DUTY_BITS-1:0] TICK_DIVIDER_RESET = 16'd1;
    localparam logic [STEP_BITS-1:0] DUTY_STEP_RESET = 11'd1;
    localparam logic [DUTY_BITS-1:0] LOW_LIMIT = 16'd10;

    localparam int CLAMP_ABOVE = 1000;
    localparam int CLAMP_TO = 999;

    localparam logic KIND_DUTY = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [7:0] CHR_CR = 8'h0d;
    localparam logic [7:0] CHR_LF = 8'h0a;
    localparam logic [7:0] CHR_TAB = 8'h09;
    localparam logic [7:0] CHR_ZERO = 8'h30;

    typedef struct packed {
        logic                  is_line;
        logic [DUTY_BITS-1:0]  duty;
        logic                  start;
        logic                  done;
        logic [VALUE_BITS-1:0] first;
        logic [VALUE_BITS-1:0] second;
    } entry_t;

    // hundreds, tens, units of a value up to 1000, hundreds saturated at 9
    function automatic logic [11:0] to_digits(input logic [VALUE_BITS-1:0] v);
        logic [15:0] hp;
        logic [3:0]  h;
        logic [9:0]  hx;
        logic [6:0]  r;
        logic [14:0] tp;
        logic [3:0]  t;
        logic [3:0]  u;
        hp = 16'(v) * 16'd41;
        h = hp[15:12];
        hx = 10'(h) * 10'd100;
        r = 7'(v - hx);
        tp = 15'(r) * 15'd205;
        t = tp[14:11];
        u = 4'(r - 7'(t) * 7'd10);
        if (h > 4'd9)
        begin
            h = 4'd9;
        end
        return {h, t, u};
    endfunction

    function automatic logic [7:0] to_ascii(input logic [3:0] d);
        return CHR_ZERO | {4'b0000, d};
    endfunction

endpackage

`default_nettype wire

// File: src/tsa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tsa_front #(
    parameter int SAMPLE_BITS = tsa_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                func,
    input  wire logic [SAMPLE_BITS-1:0]              sample_first,
    input  wire logic [SAMPLE_BITS-1:0]              sample_second,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tsa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tsa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                     push,
    output tsa_pkg::entry_t                          push_data,
    input  wire logic                                queue_full
);

    localparam logic [SAMPLE_BITS-1:0] CLAMP_ABOVE_S = SAMPLE_BITS'(tsa_pkg::CLAMP_ABOVE);
    localparam logic [tsa_pkg::VALUE_BITS-1:0] CLAMP_TO_V =
        tsa_pkg::VALUE_BITS'(tsa_pkg::CLAMP_TO);

    logic [tsa_pkg::CEILING_BITS-1:0]  duty_ceiling_reg;
    logic [tsa_pkg::DUTY_BITS-1:0]     tick_divider_reg;
    logic [tsa_pkg::STEP_BITS-1:0]     duty_step_reg;
    logic [tsa_pkg::POINT_BITS-1:0]    total_points_reg;

    logic [tsa_pkg::DUTY_BITS-1:0]  tick_count_reg, tick_count_next;
    logic [tsa_pkg::DUTY_BITS-1:0]  duty_reg, duty_next;
    logic                           step_neg_reg, step_neg_next;
    logic [tsa_pkg::POINT_BITS-1:0] point_count_reg, point_count_next;

    logic                           accept;
    logic                           is_tick;
    logic                           fire;
    logic                           room;
    logic [tsa_pkg::DUTY_BITS-1:0]  cnt_inc;
    logic [tsa_pkg::DUTY_BITS-1:0]  duty_stepped;
    logic [tsa_pkg::POINT_BITS-1:0] point_inc;
    logic [tsa_pkg::VALUE_BITS-1:0] first_clamped;
    logic [tsa_pkg::VALUE_BITS-1:0] second_clamped;

    assign in_stall = queue_full;
    assign cfg_ready = 1'b1;
    assign accept = in_valid && !in_stall;
    assign is_tick = (func == tsa_pkg::FUNC_TICK);

    assign cnt_inc = tick_count_reg + 16'd1;
    assign fire = (cnt_inc >= tick_divider_reg);
    assign duty_stepped = step_neg_reg
        ? duty_reg - tsa_pkg::DUTY_BITS'(duty_step_reg)
        : duty_reg + tsa_pkg::DUTY_BITS'(duty_step_reg);
    assign room = (point_count_reg < total_points_reg);
    assign point_inc = point_count_reg + 24'd1;

    assign first_clamped = (sample_first > CLAMP_ABOVE_S)
        ? CLAMP_TO_V : sample_first[tsa_pkg::VALUE_BITS-1:0];
    assign second_clamped = (sample_second > CLAMP_ABOVE_S)
        ? CLAMP_TO_V : sample_second[tsa_pkg::VALUE_BITS-1:0];

    always_comb
    begin
        tick_count_next = tick_count_reg;
        duty_next = duty_reg;
        step_neg_next = step_neg_reg;
        point_count_next = point_count_reg;
        push = 1'b0;
        push_data.is_line = !is_tick;
        push_data.duty = duty_reg;
        push_data.start = 1'b0;
        push_data.done = !room;
        push_data.first = first_clamped;
        push_data.second = second_clamped;
        if (accept && is_tick)
        begin
            push = 1'b1;
            if (fire)
            begin
                tick_count_next = '0;
                duty_next = duty_stepped;
                if ((duty_stepped > tsa_pkg::DUTY_BITS'(duty_ceiling_reg)) ||
                    (duty_stepped < tsa_pkg::LOW_LIMIT))
                begin
                    step_neg_next = !step_neg_reg;
                end
                push_data.duty = duty_stepped;
                push_data.start = 1'b1;
            end
            else
            begin
                tick_count_next = cnt_inc;
            end
        end
        else if (accept && room)
        begin
            push = 1'b1;
            point_count_next = point_inc;
            push_data.done = (point_inc >= total_points_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_ceiling_reg <= tsa_pkg::CEILING_RESET;
            tick_divider_reg <= tsa_pkg::TICK_DIVIDER_RESET;
            duty_step_reg <= tsa_pkg::DUTY_STEP_RESET;
            total_points_reg <= '0;
            tick_count_reg <= '0;
            duty_reg <= '0;
            step_neg_reg <= 1'b0;
            point_count_reg <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            duty_reg <= duty_next;
            step_neg_reg <= step_neg_next;
            point_count_reg <= point_count_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tsa_pkg::REG_DUTY_CEILING:
                        duty_ceiling_reg <= cfg_data[tsa_pkg::CEILING_BITS-1:0];
                    tsa_pkg::REG_TICK_DIVIDER:
                        tick_divider_reg <= cfg_data[tsa_pkg::DUTY_BITS-1:0];
                    tsa_pkg::REG_DUTY_STEP:
                        duty_step_reg <= cfg_data[tsa_pkg::STEP_BITS-1:0];
                    tsa_pkg::REG_TOTAL_POINTS:
                        total_points_reg <= cfg_data[tsa_pkg::POINT_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // a divider hit always restarts the count
    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_tick && fire |=> tick_count_reg == '0)
        else $error("tick count not cleared after divider hit");

    // a sample transaction past the total leaves the point count alone
    a_no_count_past_total: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_tick && !room |=> $stable(point_count_reg))
        else $error("point count moved past total");

endmodule

`default_nettype wire

// File: src/tsa_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tsa_queue #(
    parameter int DEPTH = tsa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tsa_pkg::entry_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output tsa_pkg::entry_t      pop_data,
    output logic                 not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    tsa_pkg::entry_t mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

endmodule

`default_nettype wire

// File: src/tsa_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tsa_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           entry_valid,
    input  wire tsa_pkg::entry_t                entry,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                kind,
    output logic [tsa_pkg::DUTY_BITS-1:0]       duty,
    output logic                                sample_start,
    output logic [7:0]                          text_byte,
    output logic                                last,
    output logic                                done_res
);

    localparam logic [3:0] POS_CR = 4'd0;
    localparam logic [3:0] POS_A_H = 4'd1;
    localparam logic [3:0] POS_A_T = 4'd2;
    localparam logic [3:0] POS_A_U = 4'd3;
    localparam logic [3:0] POS_TAB_A = 4'd4;
    localparam logic [3:0] POS_B_H = 4'd5;
    localparam logic [3:0] POS_B_T = 4'd6;
    localparam logic [3:0] POS_B_U = 4'd7;
    localparam logic [3:0] POS_TAB_B = 4'd8;
    localparam logic [3:0] POS_ZERO = 4'd9;
    localparam logic [3:0] POS_LF = 4'd10;

    tsa_pkg::entry_t cur_reg;
    logic            cur_valid_reg, cur_valid_next;
    logic [3:0]      idx_reg, idx_next;

    logic            out_valid_reg;
    logic            kind_reg;
    logic [tsa_pkg::DUTY_BITS-1:0] duty_reg;
    logic            start_reg;
    logic [7:0]      byte_reg;
    logic            last_reg;
    logic            done_reg;

    logic            out_advance;
    logic            emit;
    logic            cur_finish;
    logic [11:0]     dig_a;
    logic [11:0]     dig_b;
    logic [7:0]      line_byte;

    assign out_advance = !out_valid_reg || !out_stall;
    assign emit = cur_valid_reg && out_advance;
    assign cur_finish = !cur_reg.is_line || (idx_reg == POS_LF);
    assign pop = entry_valid && (!cur_valid_reg || (emit && cur_finish));

    assign dig_a = tsa_pkg::to_digits(cur_reg.first);
    assign dig_b = tsa_pkg::to_digits(cur_reg.second);

    always_comb
    begin
        case (idx_reg)
            POS_CR:    line_byte = tsa_pkg::CHR_CR;
            POS_A_H:   line_byte = tsa_pkg::to_ascii(dig_a[11:8]);
            POS_A_T:   line_byte = tsa_pkg::to_ascii(dig_a[7:4]);
            POS_A_U:   line_byte = tsa_pkg::to_ascii(dig_a[3:0]);
            POS_TAB_A: line_byte = tsa_pkg::CHR_TAB;
            POS_B_H:   line_byte = tsa_pkg::to_ascii(dig_b[11:8]);
            POS_B_T:   line_byte = tsa_pkg::to_ascii(dig_b[7:4]);
            POS_B_U:   line_byte = tsa_pkg::to_ascii(dig_b[3:0]);
            POS_TAB_B: line_byte = tsa_pkg::CHR_TAB;
            POS_ZERO:  line_byte = tsa_pkg::CHR_ZERO;
            POS_LF:    line_byte = tsa_pkg::CHR_LF;
            default:   line_byte = tsa_pkg::CHR_LF;
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next = POS_CR;
        end
        else if (emit && cur_finish)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg <= POS_CR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= entry;
        end
        if (emit)
        begin
            kind_reg <= cur_reg.is_line ? tsa_pkg::KIND_TEXT : tsa_pkg::KIND_DUTY;
            duty_reg <= cur_reg.duty;
            start_reg <= cur_reg.is_line ? 1'b0 : cur_reg.start;
            byte_reg <= cur_reg.is_line ? line_byte : 8'h00;
            last_reg <= cur_finish;
            done_reg <= cur_reg.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign duty = duty_reg;
    assign sample_start = start_reg;
    assign text_byte = byte_reg;
    assign last = last_reg;
    assign done_res = done_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= POS_LF)
        else $error("character index out of range");

    a_tick_single: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && !cur_reg.is_line |-> idx_reg == POS_CR)
        else $error("duty transaction advanced the character index");

    a_text_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == tsa_pkg::KIND_TEXT) |-> !start_reg)
        else $error("character result carries sample start");

endmodule

`default_nettype wire

// File: src/triangle_sweep_acquisition.sv
// triangle sweep acquisition
// input channel (in_valid / in_stall): func 0 is a timer tick, func 1 a converter
// sample pair on sample_first / sample_second. a transaction is taken when
// in_valid is high and in_stall low.
// a tick gives one duty result (kind 0); a divider hit steps duty and sets sample_start.
// a sample pair within total_points gives eleven ascii results (kind 1):
// CR, three digits, TAB, three digits, TAB, '0', LF; pairs past the total give none.
// output channel (out_valid / out_stall): a result is taken when out_valid is
// high and out_stall low; last marks the final result of a transaction.
// config channel (cfg_valid / cfg_ready): cfg_ready is always high; index 0
// duty ceiling, 1 tick_divider, 2 duty_step, 3 total_points; write only while idle.
// a transaction passes through the queue, the serializer entry and the output register.
// throughput: one result per cycle from the character serializer while out_stall is low
// and work is queued, so a tick per cycle; a sample pair holds it for eleven results.
// a queue of QUEUE_DEPTH entries sits between classifier and serializer; in_stall
// rises only when it is full. a stalled output holds its result.
// reset clears the sweep state, the point count and all queued work, and
// returns the registers to 500, 1, 1 and 0.
`timescale 1ns / 1ps
`default_nettype none

module triangle_sweep_acquisition #(
    parameter int SAMPLE_BITS = tsa_pkg::SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = tsa_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                func,
    input  wire logic [SAMPLE_BITS-1:0]              sample_first,
    input  wire logic [SAMPLE_BITS-1:0]              sample_second,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     kind,
    output logic [tsa_pkg::DUTY_BITS-1:0]            duty,
    output logic                                     sample_start,
    output logic [7:0]                               text_byte,
    output logic                                     last,
    output logic                                     done_res,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tsa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tsa_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic            push;
    tsa_pkg::entry_t push_data;
    logic            queue_full;
    logic            pop;
    tsa_pkg::entry_t pop_data;
    logic            queue_not_empty;

    tsa_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .sample_first(sample_first),
        .sample_second(sample_second),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .push_data(push_data),
        .queue_full(queue_full)
    );

    tsa_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(push_data),
        .full(queue_full),
        .pop(pop),
        .pop_data(pop_data),
        .not_empty(queue_not_empty)
    );

    tsa_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .entry_valid(queue_not_empty),
        .entry(pop_data),
        .pop(pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .duty(duty),
        .sample_start(sample_start),
        .text_byte(text_byte),
        .last(last),
        .done_res(done_res)
    );

endmodule

`default_nettype wire

// File: tb/sv/sweep_report_checker.sv
`timescale 1ns / 1ps

module sweep_report_checker #(
    parameter int SAMPLE_BITS = tsa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                func,
    input  logic [SAMPLE_BITS-1:0]              sample_first,
    input  logic [SAMPLE_BITS-1:0]              sample_second,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                kind,
    input  logic [tsa_pkg::DUTY_BITS-1:0]       duty,
    input  logic                                sample_start,
    input  logic [7:0]                          text_byte,
    input  logic                                last,
    input  logic                                done_res,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tsa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tsa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  mismatches,
    output int                                  outstanding
);

    typedef struct packed {
        logic                          kind;
        logic [tsa_pkg::DUTY_BITS-1:0] duty;
        logic                          start;
        logic [7:0]                    text;
        logic                          last;
        logic                          done;
    } sweep_result_t;

    logic [tsa_pkg::CEILING_BITS-1:0] duty_limit;
    logic [tsa_pkg::DUTY_BITS-1:0]    divider;
    logic [tsa_pkg::STEP_BITS-1:0]    step_size;
    logic [tsa_pkg::POINT_BITS-1:0]   point_total;

    logic [tsa_pkg::DUTY_BITS-1:0]    ticks;
    logic [tsa_pkg::DUTY_BITS-1:0]    duty_now;
    logic                             descending;
    logic [tsa_pkg::POINT_BITS-1:0]   points_seen;

    sweep_result_t awaited_results[$];

    function automatic logic [7:0] digit_char(input int d);
        if (d > 9)
        begin
            d = 9;
        end
        return tsa_pkg::CHR_ZERO + 8'(d);
    endfunction

    function automatic int field_diff(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic step_sweep();
        sweep_result_t r;
        logic          fire;
        fire = 1'b0;
        ticks = ticks + 16'd1;
        if (ticks >= divider)
        begin
            ticks = '0;
            fire = 1'b1;
            if (descending)
            begin
                duty_now = duty_now - tsa_pkg::DUTY_BITS'(step_size);
            end
            else
            begin
                duty_now = duty_now + tsa_pkg::DUTY_BITS'(step_size);
            end
            if (duty_now > tsa_pkg::DUTY_BITS'(duty_limit) || duty_now < tsa_pkg::LOW_LIMIT)
            begin
                descending = !descending;
            end
        end
        r.kind = tsa_pkg::KIND_DUTY;
        r.duty = duty_now;
        r.start = fire;
        r.text = 8'h00;
        r.last = 1'b1;
        r.done = (points_seen >= point_total);
        awaited_results.push_back(r);
    endtask

    task automatic format_line(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b);
        sweep_result_t r;
        logic [7:0]    chars [0:10];
        int            va;
        int            vb;
        if (points_seen >= point_total)
        begin
            return;
        end
        points_seen = points_seen + 1'b1;
        va = int'(a);
        vb = int'(b);
        if (va > tsa_pkg::CLAMP_ABOVE)
        begin
            va = tsa_pkg::CLAMP_TO;
        end
        if (vb > tsa_pkg::CLAMP_ABOVE)
        begin
            vb = tsa_pkg::CLAMP_TO;
        end
        chars[0] = tsa_pkg::CHR_CR;
        chars[1] = digit_char(va / 100);
        chars[2] = digit_char((va % 100) / 10);
        chars[3] = digit_char(va % 10);
        chars[4] = tsa_pkg::CHR_TAB;
        chars[5] = digit_char(vb / 100);
        chars[6] = digit_char((vb % 100) / 10);
        chars[7] = digit_char(vb % 10);
        chars[8] = tsa_pkg::CHR_TAB;
        chars[9] = tsa_pkg::CHR_ZERO;
        chars[10] = tsa_pkg::CHR_LF;
        for (int k = 0; k < 11; k++)
        begin
            r.kind = tsa_pkg::KIND_TEXT;
            r.duty = duty_now;
            r.start = 1'b0;
            r.text = chars[k];
            r.last = (k == 10);
            r.done = (points_seen >= point_total);
            awaited_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sweep_result_t want;
        int            bad;
        if (!rst_n)
        begin
            awaited_results.delete();
            duty_limit = tsa_pkg::CEILING_RESET;
            divider = tsa_pkg::TICK_DIVIDER_RESET;
            step_size = tsa_pkg::DUTY_STEP_RESET;
            point_total = '0;
            ticks = '0;
            duty_now = '0;
            descending = 1'b0;
            points_seen = '0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t ns: result with none awaited, kind %0h duty 0x%0h byte 0x%0h",
                             $time, kind, duty, text_byte);
                    bad = 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    bad += field_diff("kind", want.kind, kind);
                    bad += field_diff("duty", want.duty, duty);
                    bad += field_diff("sample_start", want.start, sample_start);
                    bad += field_diff("text_byte", want.text, text_byte);
                    bad += field_diff("last", want.last, last);
                    bad += field_diff("done_res", want.done, done_res);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (func == tsa_pkg::FUNC_TICK)
                begin
                    step_sweep();
                end
                else
                begin
                    format_line(sample_first, sample_second);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tsa_pkg::REG_DUTY_CEILING:
                        duty_limit = cfg_data[tsa_pkg::CEILING_BITS-1:0];
                    tsa_pkg::REG_TICK_DIVIDER:
                        divider = cfg_data[tsa_pkg::DUTY_BITS-1:0];
                    tsa_pkg::REG_DUTY_STEP:
                        step_size = cfg_data[tsa_pkg::STEP_BITS-1:0];
                    tsa_pkg::REG_TOTAL_POINTS:
                        point_total = cfg_data[tsa_pkg::POINT_BITS-1:0];
                    default:          ;
                endcase
            end
            mismatches <= mismatches + bad;
            outstanding <= awaited_results.size();
        end
    end

endmodule

// File: tb/sv/triangle_sweep_acquisition_tb.sv
`timescale 1ns / 1ps

module triangle_sweep_acquisition_tb;

    localparam int RUN_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int SBITS = tsa_pkg::SAMPLE_BITS_DEF;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic                                func;
    logic [SBITS-1:0]                    sample_first;
    logic [SBITS-1:0]                    sample_second;
    logic                                out_valid;
    logic                                out_stall;
    logic                                kind;
    logic [tsa_pkg::DUTY_BITS-1:0]       duty;
    logic                                sample_start;
    logic [7:0]                          text_byte;
    logic                                last;
    logic                                done_res;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [tsa_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
    logic [tsa_pkg::CFG_DATA_BITS-1:0]   cfg_data;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int hold_left = 0;
    int fed_points = 0;
    int point_limit = 0;
    bit quiet = 1'b0;
    logic out_taken = 1'b0;

    always #10 clk = ~clk;

    triangle_sweep_acquisition uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .sample_first(sample_first),
        .sample_second(sample_second),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .duty(duty),
        .sample_start(sample_start),
        .text_byte(text_byte),
        .last(last),
        .done_res(done_res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sweep_report_checker #(
        .SAMPLE_BITS(SBITS)
    ) watcher (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .sample_first(sample_first),
        .sample_second(sample_second),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .duty(duty),
        .sample_start(sample_start),
        .text_byte(text_byte),
        .last(last),
        .done_res(done_res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure, redrawn after each transaction and while idle
    always @(posedge clk)
    begin
        out_taken <= out_valid && !out_stall;
    end

    always @(negedge clk)
    begin
        if (out_taken || (!out_valid && hold_left == 0))
        begin
            hold_left = quiet ? 0 : $urandom_range(0, 3);
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic logic [SBITS-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0, 1:    return SBITS'($urandom_range(0, 4095));
            2, 3, 4: return SBITS'($urandom_range(0, 1000));
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return SBITS'(0);
                    1:       return SBITS'(999);
                    2:       return SBITS'(1000);
                    3:       return SBITS'(1001);
                    default: return SBITS'(4095);
                endcase
            end
        endcase
    endfunction

    task automatic put_item(input logic f, input logic [SBITS-1:0] a, input logic [SBITS-1:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        while (gap > 0)
        begin
            in_valid <= 1'b0;
            gap = gap - 1;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        sample_first <= a;
        sample_second <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (f == tsa_pkg::FUNC_SAMPLE && fed_points < point_limit)
        begin
            fed_points = fed_points + 1;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [tsa_pkg::CFG_INDEX_BITS-1:0] idx,
                             input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= tsa_pkg::CFG_DATA_BITS'(val);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == tsa_pkg::REG_TOTAL_POINTS)
        begin
            point_limit = int'(tsa_pkg::CFG_DATA_BITS'(val));
        end
    endtask

    task automatic reconfigure();
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 3))
                0:       write_reg(tsa_pkg::REG_DUTY_CEILING, 0);
                1:       write_reg(tsa_pkg::REG_DUTY_CEILING, 1000);
                2:       write_reg(tsa_pkg::REG_DUTY_CEILING, 1023);
                default: write_reg(tsa_pkg::REG_DUTY_CEILING, $urandom_range(0, 1023));
            endcase
        end
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 7))
                0:       write_reg(tsa_pkg::REG_TICK_DIVIDER, 0);
                1:       write_reg(tsa_pkg::REG_TICK_DIVIDER, 65535);
                2, 3:    write_reg(tsa_pkg::REG_TICK_DIVIDER, 1);
                default: write_reg(tsa_pkg::REG_TICK_DIVIDER, $urandom_range(2, 6));
            endcase
        end
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 5))
                0:       write_reg(tsa_pkg::REG_DUTY_STEP, 0);
                1:       write_reg(tsa_pkg::REG_DUTY_STEP, 1);
                2:       write_reg(tsa_pkg::REG_DUTY_STEP, 2000);
                3:       write_reg(tsa_pkg::REG_DUTY_STEP, 2047);
                default: write_reg(tsa_pkg::REG_DUTY_STEP, $urandom_range(1, 300));
            endcase
        end
        case ($urandom_range(0, 6))
            0:       write_reg(tsa_pkg::REG_TOTAL_POINTS, 24'hFFFFFF);
            1:       write_reg(tsa_pkg::REG_TOTAL_POINTS, fed_points);
            2:       write_reg(tsa_pkg::REG_TOTAL_POINTS, fed_points / 2);
            default: write_reg(tsa_pkg::REG_TOTAL_POINTS, fed_points + $urandom_range(5, 25));
        endcase
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = tsa_pkg::FUNC_TICK;
        sample_first = '0;
        sample_second = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tsa_pkg::REG_DUTY_CEILING;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: no points to report, duty bounces between 0 and 1
        put_item(tsa_pkg::FUNC_SAMPLE, SBITS'(123), SBITS'(456));
        put_item(tsa_pkg::FUNC_TICK, '1, '1);
        put_item(tsa_pkg::FUNC_TICK, '0, '0);
        put_item(tsa_pkg::FUNC_TICK, '0, '0);
        drain();

        // zero divider, big step from a descending duty of one forces a wrap
        write_reg(tsa_pkg::REG_DUTY_CEILING, 1000);
        write_reg(tsa_pkg::REG_TICK_DIVIDER, 0);
        write_reg(tsa_pkg::REG_DUTY_STEP, 2000);
        write_reg(tsa_pkg::REG_TOTAL_POINTS, 12);
        put_item(tsa_pkg::FUNC_TICK, '0, '0);
        put_item(tsa_pkg::FUNC_TICK, '1, '0);
        put_item(tsa_pkg::FUNC_SAMPLE, SBITS'(0), SBITS'(4095));
        put_item(tsa_pkg::FUNC_SAMPLE, SBITS'(1000), SBITS'(1001));
        put_item(tsa_pkg::FUNC_TICK, '0, '1);
        put_item(tsa_pkg::FUNC_SAMPLE, SBITS'(999), SBITS'(100));
        put_item(tsa_pkg::FUNC_SAMPLE, SBITS'(10), SBITS'(9));
        put_item(tsa_pkg::FUNC_SAMPLE, SBITS'(4095), SBITS'(0));
        put_item(tsa_pkg::FUNC_SAMPLE, pick_sample(), pick_sample());
        drain();

        // zero step, then divider lowered under the running count
        write_reg(tsa_pkg::REG_TICK_DIVIDER, 5);
        write_reg(tsa_pkg::REG_DUTY_STEP, 0);
        write_reg(tsa_pkg::REG_DUTY_CEILING, 0);
        put_item(tsa_pkg::FUNC_TICK, '0, '0);
        put_item(tsa_pkg::FUNC_TICK, '0, '0);
        put_item(tsa_pkg::FUNC_TICK, '0, '0);
        drain();
        write_reg(tsa_pkg::REG_TICK_DIVIDER, 2);
        put_item(tsa_pkg::FUNC_TICK, '0, '0);
        drain();

        // total lowered below the point count
        write_reg(tsa_pkg::REG_TOTAL_POINTS, 3);
        put_item(tsa_pkg::FUNC_SAMPLE, SBITS'(555), SBITS'(777));
        put_item(tsa_pkg::FUNC_TICK, '0, '0);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            quiet = (ph % 3 == 1);
            reconfigure();
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 1))
                begin
                    put_item(tsa_pkg::FUNC_TICK, pick_sample(), pick_sample());
                end
                else
                begin
                    put_item(tsa_pkg::FUNC_SAMPLE, pick_sample(), pick_sample());
                end
            end
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/tsa_pkg.sv
src/tsa_front.sv
src/tsa_queue.sv
src/tsa_back.sv
src/triangle_sweep_acquisition.sv
tb/sv/sweep_report_checker.sv
tb/sv/triangle_sweep_acquisition_tb.sv
